>>> hw/rtl/line_rasterizer_pixel_writer_core_macros.svh
// Assertion macros for the line rasterizer pixel writer RTL.
// Depends on nothing; every user must have signals named clock and reset in scope.
`ifndef LINE_RASTERIZER_PIXEL_WRITER_CORE_MACROS_SVH
`define LINE_RASTERIZER_PIXEL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LRPW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LRPW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

>>> hw/rtl/lrpw_pkg.sv
// Shared constants, types and helper functions of the line rasterizer pixel writer.
// Depends on nothing; the other .sv files of the RTL refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lrpw_pkg;

   localparam int COORD_BITS_DEF  = 13;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [2:0] MODE_1BPP  = 3'd0;
   localparam logic [2:0] MODE_8BPP  = 3'd1;
   localparam logic [2:0] MODE_16BPP = 3'd2;
   localparam logic [2:0] MODE_32BPP = 3'd3;

   localparam logic [2:0] REG_DEPTH  = 3'd0;
   localparam logic [2:0] REG_XOFF   = 3'd1;
   localparam logic [2:0] REG_YOFF   = 3'd2;
   localparam logic [2:0] REG_STRIDE = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;

   localparam logic [2:0]  RST_DEPTH  = MODE_16BPP;
   localparam logic [15:0] RST_STRIDE = 16'd1280;
   localparam logic [11:0] RST_WIDTH  = 12'd640;

   localparam logic [2:0] BYTES_1 = 3'd1;
   localparam logic [2:0] BYTES_2 = 3'd2;
   localparam logic [2:0] BYTES_4 = 3'd4;

   localparam logic [7:0] BYTE_MASK = 8'hff;
   localparam int RED_POS   = 11;
   localparam int GREEN_POS = 5;
   localparam int LOW_DROP  = 3;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic [2:0]  depth_mode;
      logic [11:0] x_offset;
      logic [11:0] y_offset;
      logic [15:0] line_stride;
      logic [11:0] visible_width;
   } csr_type;

   // Pack 0x00RRGGBB into RGB565 in the low half of the word.
   function automatic logic [31:0] rgb565(input logic [31:0] color);
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      r = {24'b0, color[23:16] & BYTE_MASK} >> LOW_DROP;
      g = {24'b0, color[15:8] & BYTE_MASK} >> (LOW_DROP - 1);
      b = {24'b0, color[7:0] & BYTE_MASK} >> LOW_DROP;
      return (r << RED_POS) | (g << GREEN_POS) | b;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/line_rasterizer_pixel_writer_core.sv
// Top level of the line rasterizer pixel writer: register file, front end,
// record queue and write formatter. Depends on lrpw_pkg, lrpw_front, lrpw_queue,
// lrpw_back and the assertion macro header.
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+---------------------------------------
//   req_    | in        | req_valid / req_stall  | opcode, endpoints, color
//   rsp_    | out       | rsp_valid / rsp_stall  | point, address, data, bytes, enable, last
//   csr_    | in/out    | psel, penable, pready  | five 32-bit-slot registers, addr 4*i
//
// One transaction is accepted per cycle unless req_stall is high; the DDA step in the
// front end is a single add-and-compare per accumulator, so advances stream back to back.
// An accepted advance goes through the queue write, then the offset-and-multiply stage,
// then the output register, before it is valid on rsp.
// Reset is synchronous and active high; it clears the walker, the queue and
// the pipeline valid bits and loads the register reset values.
// A stall on rsp holds the output register; the queue then absorbs up to its
// depth of advances before req_stall rises. Starts are held behind a full queue too.
`timescale 1ns / 1ps
`default_nettype none

`include "line_rasterizer_pixel_writer_core_macros.svh"

module line_rasterizer_pixel_writer_core #(
   parameter int COORD_BITS  = lrpw_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = lrpw_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,

   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_opcode,
   input  wire signed [COORD_BITS-1:0]  req_start_x,
   input  wire signed [COORD_BITS-1:0]  req_start_y,
   input  wire signed [COORD_BITS-1:0]  req_end_x,
   input  wire signed [COORD_BITS-1:0]  req_end_y,
   input  wire        [31:0]            req_pixel_color,

   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [31:0]           rsp_byte_address,
   output logic        [31:0]           rsp_write_data,
   output logic        [2:0]            rsp_write_bytes,
   output logic                         rsp_write_enable,
   output logic                         rsp_last_pixel,

   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire        [4:0]             csr_paddr,
   input  wire        [31:0]            csr_pwdata,
   output logic       [31:0]            csr_prdata,
   output logic                         csr_pready
);

   // queue record: x, y, color, last flag
   localparam int REC_W = 2 * COORD_BITS + 33;

   lrpw_pkg::csr_type   csr_ff, csr_in;
   lrpw_pkg::qstat_type qstat;

   logic                         csr_write;
   logic [2:0]                   reg_index;
   logic                         push;
   logic                         pop;
   logic                         line_active;
   logic signed [COORD_BITS-1:0] pt_x;
   logic signed [COORD_BITS-1:0] pt_y;
   logic [31:0]                  pt_color;
   logic                         pt_last;
   logic [REC_W-1:0]             q_din;
   logic [REC_W-1:0]             q_dout;
   logic                         word_write;
   logic                         start_accept;

   // ---------------- register file ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (reg_index)
            lrpw_pkg::REG_DEPTH:  csr_in.depth_mode    = csr_pwdata[2:0];
            lrpw_pkg::REG_XOFF:   csr_in.x_offset      = csr_pwdata[11:0];
            lrpw_pkg::REG_YOFF:   csr_in.y_offset      = csr_pwdata[11:0];
            lrpw_pkg::REG_STRIDE: csr_in.line_stride   = csr_pwdata[15:0];
            lrpw_pkg::REG_WIDTH:  csr_in.visible_width = csr_pwdata[11:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         lrpw_pkg::REG_DEPTH:  csr_prdata = {29'b0, csr_ff.depth_mode};
         lrpw_pkg::REG_XOFF:   csr_prdata = {20'b0, csr_ff.x_offset};
         lrpw_pkg::REG_YOFF:   csr_prdata = {20'b0, csr_ff.y_offset};
         lrpw_pkg::REG_STRIDE: csr_prdata = {16'b0, csr_ff.line_stride};
         lrpw_pkg::REG_WIDTH:  csr_prdata = {20'b0, csr_ff.visible_width};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.depth_mode    <= lrpw_pkg::RST_DEPTH;
         csr_ff.x_offset      <= '0;
         csr_ff.y_offset      <= '0;
         csr_ff.line_stride   <= lrpw_pkg::RST_STRIDE;
         csr_ff.visible_width <= lrpw_pkg::RST_WIDTH;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // ---------------- front end: decode and walk ----------------
   lrpw_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_opcode      (req_opcode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_pixel_color (req_pixel_color),
      .qstat           (qstat),
      .req_stall       (req_stall),
      .push            (push),
      .pt_x            (pt_x),
      .pt_y            (pt_y),
      .pt_color        (pt_color),
      .pt_last         (pt_last),
      .line_active     (line_active)
   );

   // ---------------- record queue ----------------
   assign q_din = {pt_x, pt_y, pt_color, pt_last};

   lrpw_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (q_din),
      .pop   (pop),
      .dout  (q_dout),
      .qstat (qstat)
   );

   // ---------------- back end: address and data formatting ----------------
   lrpw_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .q_empty          (qstat.empty),
      .q_x              (q_dout[REC_W-1 -: COORD_BITS]),
      .q_y              (q_dout[COORD_BITS+32 -: COORD_BITS]),
      .q_color          (q_dout[32:1]),
      .q_last           (q_dout[0]),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_byte_address (rsp_byte_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_write_bytes  (rsp_write_bytes),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // ---------------- assertions ----------------
   assign word_write   = rsp_valid && rsp_write_enable
                         && (rsp_write_bytes == lrpw_pkg::BYTES_4);
   assign start_accept = req_valid && !req_stall && (req_opcode == lrpw_pkg::OP_START);

   // a suppressed write never carries an address
   `LRPW_ASSERT_IMP(a_noen_zero_addr, rsp_valid && !rsp_write_enable, rsp_byte_address == '0)
   // word writes land on word boundaries
   `LRPW_ASSERT_IMP(a_word_align, word_write, rsp_byte_address[1:0] == 2'b00)
   // an accepted start always leaves a live line behind it
   `LRPW_ASSERT_NXT(a_start_arms, start_accept, line_active)

endmodule

`default_nettype wire

>>> hw/rtl/lrpw_front.sv
// Front end: takes request transactions, loads lines and runs the DDA walker.
// Depends on lrpw_pkg; feeds pixel records into lrpw_queue.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_front #(
   parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_opcode,
   input  wire signed [COORD_BITS-1:0]  req_start_x,
   input  wire signed [COORD_BITS-1:0]  req_start_y,
   input  wire signed [COORD_BITS-1:0]  req_end_x,
   input  wire signed [COORD_BITS-1:0]  req_end_y,
   input  wire        [31:0]            req_pixel_color,
   input  wire lrpw_pkg::qstat_type     qstat,
   output logic                         req_stall,
   output logic                         push,
   output logic signed [COORD_BITS-1:0] pt_x,
   output logic signed [COORD_BITS-1:0] pt_y,
   output logic        [31:0]           pt_color,
   output logic                         pt_last,
   output logic                         line_active
);

   localparam int AW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 2;

   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] col_ff, col_in;
   logic signed [COORD_BITS-1:0] row_ff, row_in;
   logic [EW-1:0]                col_err_ff, col_err_in;
   logic [EW-1:0]                row_err_ff, row_err_in;
   logic [AW-1:0]                adx_ff, adx_in;
   logic [AW-1:0]                ady_ff, ady_in;
   logic [AW-1:0]                major_ff, major_in;
   logic [1:0]                   col_step_ff, col_step_in;
   logic [1:0]                   row_step_ff, row_step_in;
   logic [EW-1:0]                count_ff, count_in;
   logic [31:0]                  color_ff, color_in;

   logic                accept;
   logic signed [AW-1:0] dx;
   logic signed [AW-1:0] dy;
   logic [AW-1:0]       adx;
   logic [AW-1:0]       ady;
   logic [EW-1:0]       col_sum;
   logic [EW-1:0]       row_sum;
   logic [EW-1:0]       major_ext;
   logic                last;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   assign dx  = AW'(req_end_x) - AW'(req_start_x);
   assign dy  = AW'(req_end_y) - AW'(req_start_y);
   assign adx = dx[AW-1] ? AW'(-dx) : AW'(dx);
   assign ady = dy[AW-1] ? AW'(-dy) : AW'(dy);

   assign major_ext = EW'(major_ff);
   assign col_sum   = col_err_ff + EW'(adx_ff);
   assign row_sum   = row_err_ff + EW'(ady_ff);
   assign last      = count_ff >= (major_ext + EW'(1));

   assign push        = accept && (req_opcode == lrpw_pkg::OP_ADVANCE) && active_ff;
   assign pt_x        = col_ff;
   assign pt_y        = row_ff;
   assign pt_color    = color_ff;
   assign pt_last     = last;
   assign line_active = active_ff;

   always_comb begin
      active_in   = active_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      col_err_in  = col_err_ff;
      row_err_in  = row_err_ff;
      adx_in      = adx_ff;
      ady_in      = ady_ff;
      major_in    = major_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      count_in    = count_ff;
      color_in    = color_ff;
      if (accept && req_opcode == lrpw_pkg::OP_START) begin
         active_in   = 1'b1;
         col_in      = req_start_x;
         row_in      = req_start_y;
         col_err_in  = '0;
         row_err_in  = '0;
         adx_in      = adx;
         ady_in      = ady;
         major_in    = (adx > ady) ? adx : ady;
         col_step_in = (dx == '0) ? 2'b00 : (dx[AW-1] ? 2'b11 : 2'b01);
         row_step_in = (dy == '0) ? 2'b00 : (dy[AW-1] ? 2'b11 : 2'b01);
         count_in    = '0;
         color_in    = req_pixel_color;
      end else if (push) begin
         // step the error accumulators, moving on overflow past the distance
         col_err_in = col_sum;
         row_err_in = row_sum;
         if (col_sum > major_ext) begin
            col_err_in = col_sum - major_ext;
            col_in     = col_ff + {{(COORD_BITS-2){col_step_ff[1]}}, col_step_ff};
         end
         if (row_sum > major_ext) begin
            row_err_in = row_sum - major_ext;
            row_in     = row_ff + {{(COORD_BITS-2){row_step_ff[1]}}, row_step_ff};
         end
         count_in = count_ff + EW'(1);
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      col_err_ff  <= col_err_in;
      row_err_ff  <= row_err_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      major_ff    <= major_in;
      col_step_ff <= col_step_in;
      row_step_ff <= row_step_in;
      count_ff    <= count_in;
      color_ff    <= color_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lrpw_queue.sv
// Short register queue of pixel records between the front end and the back end.
// Depends on lrpw_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_queue #(
   parameter int WIDTH = 59,
   parameter int DEPTH = lrpw_pkg::QUEUE_DEPTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [WIDTH-1:0]  din,
   input  wire               pop,
   output logic [WIDTH-1:0]  dout,
   output lrpw_pkg::qstat_type qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign dout  = mem_ff[rd_ptr_ff];
   assign qstat = '{empty: (count_ff == '0), full: (count_ff == CW'(DEPTH))};

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/lrpw_back.sv
// Back end: turns pixel records into framebuffer writes over two register stages.
// Depends on lrpw_pkg; pops lrpw_queue and drives the response channel.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_back #(
   parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire lrpw_pkg::csr_type       csr,
   input  wire                          q_empty,
   input  wire signed [COORD_BITS-1:0]  q_x,
   input  wire signed [COORD_BITS-1:0]  q_y,
   input  wire        [31:0]            q_color,
   input  wire                          q_last,
   output logic                         pop,
   input  wire                          rsp_stall,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic        [31:0]           rsp_byte_address,
   output logic        [31:0]           rsp_write_data,
   output logic        [2:0]            rsp_write_bytes,
   output logic                         rsp_write_enable,
   output logic                         rsp_last_pixel
);

   localparam int SUM_W  = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
   localparam int PROD_W = SUM_W - 1 + 16;

   // stage 1: shifted coordinates and row product
   logic                         s1_valid_ff;
   logic signed [COORD_BITS-1:0] s1_x_ff;
   logic signed [COORD_BITS-1:0] s1_y_ff;
   logic [31:0]                  s1_color_ff;
   logic                         s1_last_ff;
   logic                         s1_neg_ff;
   logic [2:0]                   s1_mode_ff;
   logic [31:0]                  s1_ux_ff;
   logic [31:0]                  s1_prod_ff;

   // stage 2: output register
   logic                         out_valid_ff;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic signed [COORD_BITS-1:0] out_y_ff;
   logic [31:0]                  out_addr_ff, out_addr_in;
   logic [31:0]                  out_data_ff, out_data_in;
   logic [2:0]                   out_bytes_ff, out_bytes_in;
   logic                         out_en_ff, out_en_in;
   logic                         out_last_ff;

   logic                advance_out;
   logic                advance_s1;
   logic signed [SUM_W-1:0] sx;
   logic signed [SUM_W-1:0] sy;
   logic [15:0]         factor;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W+31:0]  prod_ext;
   logic [SUM_W+30:0]   ux_ext;

   assign advance_out = !out_valid_ff || !rsp_stall;
   assign advance_s1  = !s1_valid_ff || advance_out;
   assign pop         = !q_empty && advance_s1;

   assign sx = {{(SUM_W-COORD_BITS){q_x[COORD_BITS-1]}}, q_x}
             + {{(SUM_W-12){1'b0}}, csr.x_offset};
   assign sy = {{(SUM_W-COORD_BITS){q_y[COORD_BITS-1]}}, q_y}
             + {{(SUM_W-12){1'b0}}, csr.y_offset};

   assign factor   = (csr.depth_mode == lrpw_pkg::MODE_1BPP) ? {4'b0, csr.visible_width}
                                                              : csr.line_stride;
   assign prod     = PROD_W'(sy[SUM_W-2:0]) * PROD_W'(factor);
   assign prod_ext = {32'b0, prod};
   assign ux_ext   = {32'b0, sx[SUM_W-2:0]};

   always_comb begin
      out_addr_in  = '0;
      out_data_in  = '0;
      out_bytes_in = lrpw_pkg::BYTES_1;
      out_en_in    = !s1_neg_ff;
      unique case (s1_mode_ff) inside
         lrpw_pkg::MODE_1BPP, lrpw_pkg::MODE_8BPP: begin
            out_addr_in = s1_ux_ff + s1_prod_ff;
            out_data_in = {24'b0, s1_color_ff[7:0] & lrpw_pkg::BYTE_MASK};
         end
         lrpw_pkg::MODE_16BPP: begin
            out_addr_in  = {s1_ux_ff[30:0], 1'b0} + {s1_prod_ff[31:1], 1'b0};
            out_data_in  = lrpw_pkg::rgb565(s1_color_ff);
            out_bytes_in = lrpw_pkg::BYTES_2;
         end
         lrpw_pkg::MODE_32BPP: begin
            out_addr_in  = {s1_ux_ff[29:0], 2'b0} + {s1_prod_ff[31:2], 2'b0};
            out_data_in  = s1_color_ff;
            out_bytes_in = lrpw_pkg::BYTES_4;
         end
         default: begin
            out_en_in = 1'b0;
         end
      endcase
      if (!out_en_in) begin
         out_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance_s1) begin
            s1_valid_ff <= pop;
         end
         if (advance_out) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
      if (pop) begin
         s1_x_ff     <= q_x;
         s1_y_ff     <= q_y;
         s1_color_ff <= q_color;
         s1_last_ff  <= q_last;
         s1_neg_ff   <= sx[SUM_W-1] || sy[SUM_W-1];
         s1_mode_ff  <= csr.depth_mode;
         s1_ux_ff    <= ux_ext[31:0];
         s1_prod_ff  <= prod_ext[31:0];
      end
      if (advance_out && s1_valid_ff) begin
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_addr_ff  <= out_addr_in;
         out_data_ff  <= out_data_in;
         out_bytes_ff <= out_bytes_in;
         out_en_ff    <= out_en_in;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_write_data   = out_data_ff;
   assign rsp_write_bytes  = out_bytes_ff;
   assign rsp_write_enable = out_en_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule

`default_nettype wire
